>>> rtl/rmd160_pkg.sv
// rmd160_pkg: constants, round tables and step functions of the ripemd-160 core
// no dependencies; used by all rtl modules of the core
`timescale 1ns / 1ps
`default_nettype none
package rmd160_pkg;

   localparam int unsigned NumSteps = 80;
   localparam int unsigned NumWords = 16;

   typedef logic [31:0] word_type;
   typedef logic [6:0]  step_type;
   typedef logic [3:0]  sel_type;
   typedef logic [4:0]  rot_type;

   // working variables of one line
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } line_state_type;

   // padded message block, word 15 first in the packed order
   typedef word_type [NumWords-1:0] block_type;

   localparam word_type ChainInit0 = 32'h67452301;
   localparam word_type ChainInit1 = 32'hEFCDAB89;
   localparam word_type ChainInit2 = 32'h98BADCFE;
   localparam word_type ChainInit3 = 32'h10325476;
   localparam word_type ChainInit4 = 32'hC3D2E1F0;

   localparam word_type PadWord8  = 32'h00000080;
   localparam word_type PadWord14 = 32'h00000100;

   localparam logic [3:0] SelLeft [0:NumSteps-1] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
      4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
      4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
      4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
      4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
      4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
      4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
      4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
   };

   localparam logic [3:0] SelRight [0:NumSteps-1] = '{
      4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
      4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
      4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
      4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
      4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
      4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
      4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
      4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
      4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
      4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
   };

   localparam logic [4:0] RotLeft [0:NumSteps-1] = '{
      5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9,
      5'd11, 5'd13, 5'd14, 5'd15, 5'd6, 5'd7, 5'd9, 5'd8,
      5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15,
      5'd7, 5'd12, 5'd15, 5'd9, 5'd11, 5'd7, 5'd13, 5'd12,
      5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15,
      5'd14, 5'd8, 5'd13, 5'd6, 5'd5, 5'd12, 5'd7, 5'd5,
      5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8,
      5'd9, 5'd14, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd12,
      5'd9, 5'd15, 5'd5, 5'd11, 5'd6, 5'd8, 5'd13, 5'd12,
      5'd5, 5'd12, 5'd13, 5'd14, 5'd11, 5'd8, 5'd5, 5'd6
   };

   localparam logic [4:0] RotRight [0:NumSteps-1] = '{
      5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5,
      5'd7, 5'd7, 5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd6,
      5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11,
      5'd7, 5'd7, 5'd12, 5'd7, 5'd6, 5'd15, 5'd13, 5'd11,
      5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14,
      5'd12, 5'd13, 5'd5, 5'd14, 5'd13, 5'd13, 5'd7, 5'd5,
      5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14,
      5'd6, 5'd9, 5'd12, 5'd9, 5'd12, 5'd5, 5'd15, 5'd8,
      5'd8, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd14, 5'd6,
      5'd8, 5'd13, 5'd6, 5'd5, 5'd15, 5'd13, 5'd11, 5'd11
   };

   localparam word_type AddLeft [0:4] = '{
      32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
   };

   localparam word_type AddRight [0:4] = '{
      32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
   };

   // boolean function of a round, selected by a constant
   function automatic word_type mix_fn(input int unsigned sel, input word_type x,
                                       input word_type y, input word_type z);
      word_type r;
      case (sel)
         0: r = x ^ y ^ z;
         1: r = (x & y) | (~x & z);
         2: r = (x | ~y) ^ z;
         3: r = (x & z) | (y & ~z);
         default: r = x ^ (y | ~z);
      endcase
      return r;
   endfunction

   // one step of one line; all table lookups fold to constants
   function automatic line_state_type step_fn(input line_state_type s, input word_type w,
                                              input int unsigned fsel, input word_type k,
                                              input int unsigned rot);
      line_state_type n;
      word_type t;
      t = s.a + mix_fn(fsel, s.b, s.c, s.d) + w + k;
      t = ((t << rot) | (t >> ((32 - rot) % 32))) + s.e;
      n.a = s.e;
      n.e = s.d;
      n.d = {s.c[21:0], s.c[31:22]};
      n.c = s.b;
      n.b = t;
      return n;
   endfunction

endpackage
`default_nettype wire

>>> rtl/rmd160_stage.sv
// rmd160_stage: one pipeline stage that runs a fixed span of steps on both lines
// depends on rmd160_pkg
`timescale 1ns / 1ps
`default_nettype none
module rmd160_stage #(
   parameter int unsigned FirstStep = 0,
   parameter int unsigned StepCount = 4
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         valid_in,
   input  rmd160_pkg::block_type       block_in,
   input  rmd160_pkg::line_state_type  left_in,
   input  rmd160_pkg::line_state_type  right_in,
   output logic                        valid_out,
   output rmd160_pkg::block_type       block_out,
   output rmd160_pkg::line_state_type  left_out,
   output rmd160_pkg::line_state_type  right_out
);
   import rmd160_pkg::*;

   logic           valid_ff;
   block_type      block_ff;
   line_state_type left_ff, left_in_c;
   line_state_type right_ff, right_in_c;

   // unrolled steps of this stage
   always_comb begin
      line_state_type l, r;
      l = left_in;
      r = right_in;
      for (int unsigned i = 0; i < StepCount; i++) begin
         l = step_fn(l, block_in[SelLeft[FirstStep+i]], (FirstStep + i) / 16,
                     AddLeft[(FirstStep + i) / 16], int'(RotLeft[FirstStep+i]));
         r = step_fn(r, block_in[SelRight[FirstStep+i]], 4 - (FirstStep + i) / 16,
                     AddRight[(FirstStep + i) / 16], int'(RotRight[FirstStep+i]));
      end
      left_in_c  = l;
      right_in_c = r;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      block_ff <= block_in;
      left_ff  <= left_in_c;
      right_ff <= right_in_c;
   end

   assign valid_out = valid_ff;
   assign block_out = block_ff;
   assign left_out  = left_ff;
   assign right_out = right_ff;
endmodule
`default_nettype wire

>>> rtl/ripemd160_hash_32_byte_message_core.sv
// ripemd160_hash_32_byte_message_core: top level, padding, step pipeline and final combine
// depends on rmd160_pkg and rmd160_stage
// pipeline: one step a stage at default; the stage registers are followed by the result register
// throughput: one message per cycle; busy is never raised, each stage holds one item
// the receiver cannot stall, so results leave on a strobe with no backpressure
// reset (synchronous, active high) clears only the valid bits of the pipeline
`timescale 1ns / 1ps
`default_nettype none
module ripemd160_hash_32_byte_message_core #(
   parameter int unsigned StepsPerStage = 1
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  rmd160_pkg::word_type    req_msg_word0,
   input  rmd160_pkg::word_type    req_msg_word1,
   input  rmd160_pkg::word_type    req_msg_word2,
   input  rmd160_pkg::word_type    req_msg_word3,
   input  rmd160_pkg::word_type    req_msg_word4,
   input  rmd160_pkg::word_type    req_msg_word5,
   input  rmd160_pkg::word_type    req_msg_word6,
   input  rmd160_pkg::word_type    req_msg_word7,
   output logic                    rsp_valid,
   output rmd160_pkg::word_type    rsp_digest_word0,
   output rmd160_pkg::word_type    rsp_digest_word1,
   output rmd160_pkg::word_type    rsp_digest_word2,
   output rmd160_pkg::word_type    rsp_digest_word3,
   output rmd160_pkg::word_type    rsp_digest_word4
);
   import rmd160_pkg::*;

   localparam int unsigned NumStages = NumSteps / StepsPerStage;

   logic           valid_c [0:NumStages];
   block_type      block_c [0:NumStages];
   line_state_type left_c  [0:NumStages];
   line_state_type right_c [0:NumStages];
   line_state_type init_state;

   logic     rsp_valid_ff;
   word_type digest0_ff, digest1_ff, digest2_ff, digest3_ff, digest4_ff;

   assign busy = 1'b0;

   // padded block and initial chaining values
   assign init_state = '{a: ChainInit0, b: ChainInit1, c: ChainInit2,
                         d: ChainInit3, e: ChainInit4};
   assign valid_c[0] = start;
   assign left_c[0]  = init_state;
   assign right_c[0] = init_state;
   always_comb begin
      block_c[0]     = '0;
      block_c[0][0]  = req_msg_word0;
      block_c[0][1]  = req_msg_word1;
      block_c[0][2]  = req_msg_word2;
      block_c[0][3]  = req_msg_word3;
      block_c[0][4]  = req_msg_word4;
      block_c[0][5]  = req_msg_word5;
      block_c[0][6]  = req_msg_word6;
      block_c[0][7]  = req_msg_word7;
      block_c[0][8]  = PadWord8;
      block_c[0][14] = PadWord14;
   end

   // step pipeline
   for (genvar g = 0; g < NumStages; g++) begin : g_stage
      rmd160_stage #(
         .FirstStep (g * StepsPerStage),
         .StepCount (StepsPerStage)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_c[g]),
         .block_in  (block_c[g]),
         .left_in   (left_c[g]),
         .right_in  (right_c[g]),
         .valid_out (valid_c[g+1]),
         .block_out (block_c[g+1]),
         .left_out  (left_c[g+1]),
         .right_out (right_c[g+1])
      );
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_c[NumStages];
      end
   end

   // final combine of both lines with the chaining values
   always_ff @(posedge clock) begin
      digest0_ff <= ChainInit1 + left_c[NumStages].c + right_c[NumStages].d;
      digest1_ff <= ChainInit2 + left_c[NumStages].d + right_c[NumStages].e;
      digest2_ff <= ChainInit3 + left_c[NumStages].e + right_c[NumStages].a;
      digest3_ff <= ChainInit4 + left_c[NumStages].a + right_c[NumStages].b;
      digest4_ff <= ChainInit0 + left_c[NumStages].b + right_c[NumStages].c;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_word0 = digest0_ff;
   assign rsp_digest_word1 = digest1_ff;
   assign rsp_digest_word2 = digest2_ff;
   assign rsp_digest_word3 = digest3_ff;
   assign rsp_digest_word4 = digest4_ff;
endmodule
`default_nettype wire

>>> bench/tb_ripemd160_hash_32_byte_message_core.sv
// tb_ripemd160_hash_32_byte_message_core: self-checking bench for the ripemd-160 core
// depends on rmd160_pkg (word type) and ripemd160_hash_32_byte_message_core
`timescale 1ns / 1ps
module tb_ripemd160_hash_32_byte_message_core;
   import rmd160_pkg::word_type;

   typedef struct packed {
      word_type [7:0] w;
   } msg_type;

   typedef struct packed {
      word_type [4:0] w;
   } digest_type;

   localparam int DirectedCount = 20;
   localparam int RandomCount   = 1400;
   localparam int CycleLimit    = 200000;
   localparam int DrainCycles   = 40;

   // step tables of the two lines
   localparam logic [3:0] WordLeft [0:79] = '{
      0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15, 7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
      3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12, 1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
      4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
   localparam logic [3:0] WordRight [0:79] = '{
      5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12, 6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
      15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13, 8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
      12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
   localparam logic [4:0] ShiftLeft [0:79] = '{
      11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8, 7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
      11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5, 11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
      9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
   localparam logic [4:0] ShiftRight [0:79] = '{
      8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6, 9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
      9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5, 15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
      8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
   localparam word_type KLeft  [0:4] = '{32'h0, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                         32'hA953FD4E};
   localparam word_type KRight [0:4] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
                                         32'h7A6D76E9, 32'h0};
   localparam word_type Iv [0:4] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                     32'h10325476, 32'hC3D2E1F0};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   msg_type    req_msg = '0;
   logic       rsp_valid;
   digest_type rsp_digest;

   msg_type    pending_msgs [$];
   digest_type expected_digests [$];
   logic       stim_done = 1'b0;
   logic       hold_off = 1'b0;
   int         fail_count = 0;
   int         cycle_count = 0;
   int         gap_left = 0;

   ripemd160_hash_32_byte_message_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_msg_word0(req_msg.w[0]), .req_msg_word1(req_msg.w[1]),
      .req_msg_word2(req_msg.w[2]), .req_msg_word3(req_msg.w[3]),
      .req_msg_word4(req_msg.w[4]), .req_msg_word5(req_msg.w[5]),
      .req_msg_word6(req_msg.w[6]), .req_msg_word7(req_msg.w[7]),
      .rsp_valid(rsp_valid),
      .rsp_digest_word0(rsp_digest.w[0]), .rsp_digest_word1(rsp_digest.w[1]),
      .rsp_digest_word2(rsp_digest.w[2]), .rsp_digest_word3(rsp_digest.w[3]),
      .rsp_digest_word4(rsp_digest.w[4])
   );

   always #1 clock = ~clock;

   function automatic word_type rol(word_type v, int n);
      return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
   endfunction

   function automatic word_type round_fn(int f, word_type x, word_type y, word_type z);
      case (f)
         0: return x ^ y ^ z;
         1: return (x & y) | (~x & z);
         2: return (x | ~y) ^ z;
         3: return (x & z) | (y & ~z);
         default: return x ^ (y | ~z);
      endcase
   endfunction

   // digest of one padded 32-byte message
   function automatic digest_type rmd160_digest(msg_type m);
      word_type   blk [0:15];
      word_type   al, bl, cl, dl, el, ar, br, cr, dr, er, t;
      digest_type d;
      int         r;
      for (int i = 0; i < 16; i++) blk[i] = (i < 8) ? m.w[i] : 32'h0;
      blk[8] = 32'h80;
      blk[14] = 32'd256;
      al = Iv[0]; bl = Iv[1]; cl = Iv[2]; dl = Iv[3]; el = Iv[4];
      ar = Iv[0]; br = Iv[1]; cr = Iv[2]; dr = Iv[3]; er = Iv[4];
      for (int j = 0; j < 80; j++) begin
         r = j / 16;
         t = rol(al + round_fn(r, bl, cl, dl) + blk[WordLeft[j]] + KLeft[r], ShiftLeft[j]) + el;
         al = el; el = dl; dl = rol(cl, 10); cl = bl; bl = t;
         t = rol(ar + round_fn(4 - r, br, cr, dr) + blk[WordRight[j]] + KRight[r],
                 ShiftRight[j]) + er;
         ar = er; er = dr; dr = rol(cr, 10); cr = br; br = t;
      end
      d.w[0] = Iv[1] + cl + dr;
      d.w[1] = Iv[2] + dl + er;
      d.w[2] = Iv[3] + el + ar;
      d.w[3] = Iv[4] + al + br;
      d.w[4] = Iv[0] + bl + cr;
      return d;
   endfunction

   function automatic msg_type random_msg();
      msg_type m;
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(0, 5))
            0: m.w[i] = 32'h0;
            1: m.w[i] = 32'hFFFFFFFF;
            2: m.w[i] = 32'h1 << $urandom_range(0, 31);
            default: m.w[i] = $urandom;
         endcase
      end
      return m;
   endfunction

   // stimulus: directed extremes, then random messages
   initial begin
      msg_type m;
      pending_msgs.push_back('0);
      pending_msgs.push_back('1);
      for (int i = 0; i < 8; i++) begin
         m = '0; m.w[i] = 32'hFFFFFFFF; pending_msgs.push_back(m);
         m = '1; m.w[i] = 32'h0;        pending_msgs.push_back(m);
      end
      for (int i = 0; i < DirectedCount - 18; i++) begin
         m = '0;
         for (int k = 0; k < 8; k++) m.w[k] = {4{8'h55 << i}};
         pending_msgs.push_back(m);
      end
      for (int i = 0; i < RandomCount; i++) pending_msgs.push_back(random_msg());
   end

   // driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 10) reset <= 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            expected_digests.push_back(rmd160_digest(req_msg));
            if (pending_msgs.size() == RandomCount / 2) hold_off <= 1'b1;
         end
         if (start && busy) begin
            // keep the current item presented
         end else if (hold_off) begin
            start <= 1'b0;
            if (expected_digests.size() == 0 && !(start && !busy)) hold_off <= 1'b0;
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_msgs.size() > 0) begin
            start <= 1'b1;
            req_msg <= pending_msgs.pop_front();
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         end else begin
            start <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // monitor: compare each transfer with the oldest expected digest
   always @(posedge clock) begin
      digest_type exp_d;
      int         bad;
      bad = 0;
      if (!reset && rsp_valid) begin
         if (expected_digests.size() == 0) begin
            $error("digest with none expected");
            bad = 1;
         end else begin
            exp_d = expected_digests.pop_front();
            for (int i = 0; i < 5; i++)
               if (exp_d.w[i] !== rsp_digest.w[i]) begin
                  $error("digest_word%0d expected %h actual %h", i, exp_d.w[i], rsp_digest.w[i]);
                  bad = bad + 1;
               end
         end
      end
      if (bad != 0) fail_count <= fail_count + bad;
   end

   // end of run and timeout
   initial begin
      wait (stim_done && expected_digests.size() == 0 || cycle_count >= CycleLimit);
      if (cycle_count >= CycleLimit) begin
         $display("Test completed with failures");
      end else begin
         repeat (DrainCycles) @(posedge clock);
         if (fail_count == 0 && expected_digests.size() == 0)
            $display("Test completed successfully");
         else
            $display("Test completed with failures");
      end
      $finish;
   end
endmodule
